// ----- design/sorted_insert_table_top_defines.svh -----
// Assertion macros shared by the sorted insert table RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef SORTED_INSERT_TABLE_TOP_DEFINES_SVH
`define SORTED_INSERT_TABLE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define SIT_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SIT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIT_ASSERT(name, clk, rst_n, prop, msg)
`define SIT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

// ----- design/sit_pkg.sv -----
// Types and constants for the sorted insert table.
// No dependencies; used by the controller, the datapath and the top level.
package sit_pkg;

    localparam int ACT_W = 2;
    localparam int KEY_W = 32;
    localparam int IDX_W = 6;
    localparam int POS_W = 7;
    localparam int ST_W  = 2;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_WR_KEY,
        S_READ_RD,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic set_miss;
        logic scan_rd;
        logic scan_step;
        logic shift_rd;
        logic shift_wr;
        logic wr_key;
        logic idx_rd;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic is_insert;
        logic is_search;
        logic is_read;
        logic empty;
        logic scan_hit;
        logic scan_last;
        logic full;
        logic shift_end;
        logic idx_ok;
        logic out_free;
    } t_sts;

endpackage

// ----- design/sit_if.sv -----
// Valid/ready channels for request and result beats.
// Depends on nothing; field widths match sit_pkg.
interface sit_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  action;
    logic signed [31:0] value;
    logic        [5:0]  index;

    modport source (output valid, action, value, index, input ready);
    modport sink   (input valid, action, value, index, output ready);
endinterface

interface sit_out_if;
    logic               valid;
    logic               ready;
    logic        [6:0]  position;
    logic               found;
    logic signed [31:0] entry;
    logic        [6:0]  count;
    logic        [1:0]  status;

    modport source (output valid, position, found, entry, count, status, input ready);
    modport sink   (input valid, position, found, entry, count, status, output ready);
endinterface

// ----- design/sit_ctrl.sv -----
// Sequencing state machine for the sorted insert table.
// Depends on sit_pkg and the assertion macros header.
`include "sorted_insert_table_top_defines.svh"

module sit_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sit_pkg::t_sts  i_sts,
    output sit_pkg::t_cmd  o_cmd
);
    import sit_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   w_post_ins;
    logic   w_keyed;

    assign w_keyed    = i_sts.is_insert || i_sts.is_search;
    assign w_post_ins = i_sts.is_insert && !i_sts.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                if (w_keyed) begin
                    if (i_sts.empty) n_state = w_post_ins ? S_SHIFT_CHK : S_DONE;
                    else n_state = S_SCAN_RD;
                end else if (i_sts.is_read) begin
                    n_state = i_sts.idx_ok ? S_READ_RD : S_DONE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN_RD: n_state = S_SCAN_CMP;
            S_SCAN_CMP: begin
                if (i_sts.scan_hit || i_sts.scan_last) begin
                    n_state = w_post_ins ? S_SHIFT_CHK : S_DONE;
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_CHK: n_state = i_sts.shift_end ? S_WR_KEY : S_SHIFT_WR;
            S_SHIFT_WR:  n_state = S_SHIFT_CHK;
            S_WR_KEY:    n_state = S_DONE;
            S_READ_RD:   n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DISPATCH:  o_cmd.set_miss  = w_keyed && i_sts.empty;
            S_SCAN_RD:   o_cmd.scan_rd   = 1'b1;
            S_SCAN_CMP:  o_cmd.scan_step = 1'b1;
            S_SHIFT_CHK: o_cmd.shift_rd  = !i_sts.shift_end;
            S_SHIFT_WR:  o_cmd.shift_wr  = 1'b1;
            S_WR_KEY:    o_cmd.wr_key    = 1'b1;
            S_READ_RD:   o_cmd.idx_rd    = 1'b1;
            S_DONE:      o_cmd.finish    = i_sts.out_free;
            default:     o_cmd           = '0;
        endcase
    end

    `SIT_ASSERT(a_finish_when_free, i_clk, i_rst_n, o_cmd.finish |-> i_sts.out_free, "result beat issued while output busy")
    `SIT_ASSERT(a_one_read, i_clk, i_rst_n, $onehot0({o_cmd.scan_rd, o_cmd.shift_rd, o_cmd.idx_rd}), "read port used twice")
    `SIT_ASSERT(a_load_dispatch, i_clk, i_rst_n, o_cmd.load |=> r_state == S_DISPATCH, "accepted beat not dispatched")

endmodule

// ----- design/sit_datapath.sv -----
// Table memory, scan and shift counters, entry count and result register.
// Depends on sit_pkg, sit_if and the assertion macros header.
`include "sorted_insert_table_top_defines.svh"

module sit_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [sit_pkg::ACT_W-1:0]          i_action,
    input  logic signed [sit_pkg::KEY_W-1:0]   i_value,
    input  logic [sit_pkg::IDX_W-1:0]          i_index,
    input  sit_pkg::t_cmd                      i_cmd,
    output sit_pkg::t_sts                      o_sts,
    sit_out_if.source                          o_out
);
    import sit_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int XW = (CW > IDX_W) ? CW : IDX_W;

    logic signed [KEY_W-1:0] mem [TABLE_DEPTH];

    logic [ACT_W-1:0]        r_act;
    logic signed [KEY_W-1:0] r_key;
    logic [IDX_W-1:0]        r_idx;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_i;
    logic [CW-1:0]           r_j;
    logic [CW-1:0]           r_pos;
    logic                    r_hit;
    logic                    r_full;
    logic signed [KEY_W-1:0] r_rd_data;

    logic                    r_out_valid;
    logic [POS_W-1:0]        r_o_position;
    logic                    r_o_found;
    logic signed [KEY_W-1:0] r_o_entry;
    logic [POS_W-1:0]        r_o_count;
    logic [ST_W-1:0]         r_o_status;

    logic                    w_rd_en;
    logic [AW-1:0]           w_rd_addr;
    logic                    w_wr_en;
    logic [AW-1:0]           w_wr_addr;
    logic signed [KEY_W-1:0] w_wr_data;
    logic [CW-1:0]           w_jm1;
    logic [AW+IDX_W-1:0]     w_idx_ext;
    logic [CW+POS_W-1:0]     w_pos_ext;
    logic [CW+POS_W-1:0]     w_cnt_ext;
    logic                    w_keyed;
    logic [ST_W-1:0]         w_status;

    assign o_sts.is_insert = (r_act == ACT_INSERT);
    assign o_sts.is_search = (r_act == ACT_SEARCH);
    assign o_sts.is_read   = (r_act == ACT_READ);
    assign o_sts.empty     = (r_count == '0);
    assign o_sts.scan_hit  = (r_rd_data >= r_key);
    assign o_sts.scan_last = ((r_i + CW'(1)) == r_count);
    assign o_sts.full      = r_full;
    assign o_sts.shift_end = (r_j == r_pos);
    assign o_sts.idx_ok    = (XW'(r_idx) < XW'(r_count));
    assign o_sts.out_free  = !r_out_valid || o_out.ready;

    assign w_jm1     = r_j - CW'(1);
    assign w_idx_ext = (AW+IDX_W)'(r_idx);
    assign w_pos_ext = (CW+POS_W)'(r_pos);
    assign w_cnt_ext = (CW+POS_W)'(r_count);
    assign w_keyed   = o_sts.is_insert || o_sts.is_search;

    assign w_rd_en = i_cmd.scan_rd || i_cmd.shift_rd || i_cmd.idx_rd;
    assign w_wr_en = i_cmd.shift_wr || i_cmd.wr_key;

    always_comb begin
        w_rd_addr = r_i[AW-1:0];
        if (i_cmd.shift_rd) w_rd_addr = w_jm1[AW-1:0];
        else if (i_cmd.idx_rd) w_rd_addr = w_idx_ext[AW-1:0];
    end

    always_comb begin
        w_wr_addr = r_pos[AW-1:0];
        w_wr_data = r_key;
        if (i_cmd.shift_wr) begin
            w_wr_addr = r_j[AW-1:0];
            w_wr_data = r_rd_data;
        end
    end

    always_comb begin
        w_status = ST_OK;
        if (o_sts.is_insert && r_full) w_status = ST_FULL;
        else if (o_sts.is_read && !o_sts.idx_ok) w_status = ST_BAD_INDEX;
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) r_rd_data <= mem[w_rd_addr];
        if (w_wr_en) mem[w_wr_addr] <= w_wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act  <= i_action;
            r_key  <= i_value;
            r_idx  <= i_index;
            r_i    <= '0;
            r_j    <= r_count;
            r_pos  <= '0;
            r_hit  <= 1'b0;
            r_full <= (r_count == CW'(TABLE_DEPTH));
        end
        if (i_cmd.set_miss) begin
            r_pos <= r_count;
            r_hit <= 1'b0;
        end
        if (i_cmd.scan_step) begin
            if (o_sts.scan_hit) begin
                r_pos <= r_i;
                r_hit <= 1'b1;
            end else if (o_sts.scan_last) begin
                r_pos <= r_count;
            end else begin
                r_i <= r_i + CW'(1);
            end
        end
        if (i_cmd.shift_wr) r_j <= w_jm1;
        if (i_cmd.finish) begin
            r_o_position <= w_keyed ? w_pos_ext[POS_W-1:0] : '0;
            r_o_found    <= r_hit;
            r_o_entry    <= (o_sts.is_read && o_sts.idx_ok) ? r_rd_data : '0;
            r_o_count    <= w_cnt_ext[POS_W-1:0];
            r_o_status   <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_key) r_count <= r_count + CW'(1);
            if (i_cmd.finish) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.position = r_o_position;
    assign o_out.found    = r_o_found;
    assign o_out.entry    = r_o_entry;
    assign o_out.count    = r_o_count;
    assign o_out.status   = r_o_status;

    `SIT_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CW'(TABLE_DEPTH), "entry count above depth")
    `SIT_ASSERT(a_shift_above_pos, i_clk, i_rst_n, i_cmd.shift_wr |-> r_j != r_pos, "shift past insert slot")
    `SIT_ASSERT(a_finish_valid, i_clk, i_rst_n, i_cmd.finish |=> r_out_valid, "finished beat not presented")

endmodule

// ----- design/sorted_insert_table_top.sv -----
// Sorted insert table: ascending table of signed 32-bit keys in a single-port
// memory. Insert and search walk the table from index 0, reading and then
// comparing each entry examined; insert then moves each later entry up, reading
// it and then writing it one slot higher. The one memory port serves a read or
// a write in any cycle, never both. One request is in work at a time; a
// finished result waits in the output register while the next request is
// accepted. Reads of the table need no clearing pass.
module sorted_insert_table_top #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sit_in_if.sink     i_in,
    sit_out_if.source  o_out
);
    import sit_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    sit_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    sit_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_action (i_in.action),
        .i_value  (i_in.value),
        .i_index  (i_in.index),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_out    (o_out)
    );

endmodule

// ----- test/sit_table_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the sorted insert table: watches the request and result channels,
// keeps its own copy of the table and compares every result beat field by field.
// Depends on sit_pkg and the channel interfaces in sit_if.sv.
module sit_table_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sit_in_if    i_req,
    sit_out_if   i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    import sit_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0]        position;
        logic                    found;
        logic signed [KEY_W-1:0] entry;
        logic [POS_W-1:0]        count;
        logic [ST_W-1:0]         status;
    } t_table_result;

    logic signed [KEY_W-1:0] table_keys [TABLE_DEPTH];
    int unsigned             key_count;
    t_table_result           expected_q [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        key_count    = 0;
    end

    function automatic t_table_result apply_request(
        input logic [ACT_W-1:0]        act,
        input logic signed [KEY_W-1:0] key,
        input logic [IDX_W-1:0]        idx
    );
        t_table_result res;
        int unsigned   slot;
        logic          hit;
        res  = '0;
        slot = key_count;
        hit  = 1'b0;
        if (act == ACT_INSERT || act == ACT_SEARCH) begin
            for (int i = int'(key_count) - 1; i >= 0; i--) begin
                if (table_keys[i] >= key) begin
                    slot = i;
                    hit  = 1'b1;
                end
            end
            res.position = slot[POS_W-1:0];
            res.found    = hit;
            if (act == ACT_INSERT) begin
                if (key_count >= TABLE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int unsigned i = key_count; i > slot; i--)
                        table_keys[i] = table_keys[i - 1];
                    table_keys[slot] = key;
                    key_count++;
                end
            end
        end else if (act == ACT_READ) begin
            if (idx < key_count)
                res.entry = table_keys[idx];
            else
                res.status = ST_BAD_INDEX;
        end
        res.count = key_count[POS_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [KEY_W-1:0] got,
                                   input logic [KEY_W-1:0] want);
        $display("[%0t] result mismatch on %s: got %h, want %h", $time, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_table_result want;
        t_table_result got;
        if (i_rst_n) begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.position = i_rsp.position;
                got.found    = i_rsp.found;
                got.entry    = i_rsp.entry;
                got.count    = i_rsp.count;
                got.status   = i_rsp.status;
                if (expected_q.size() == 0) begin
                    report_mismatch("beat with nothing pending", got.entry, '0);
                end else begin
                    want = expected_q.pop_front();
                    if (got.position !== want.position)
                        report_mismatch("position", KEY_W'(got.position),
                                        KEY_W'(want.position));
                    if (got.found !== want.found)
                        report_mismatch("found", KEY_W'(got.found), KEY_W'(want.found));
                    if (got.entry !== want.entry)
                        report_mismatch("entry", got.entry, want.entry);
                    if (got.count !== want.count)
                        report_mismatch("count", KEY_W'(got.count), KEY_W'(want.count));
                    if (got.status !== want.status)
                        report_mismatch("status", KEY_W'(got.status), KEY_W'(want.status));
                end
            end
            if (i_req.valid && i_req.ready)
                expected_q.push_back(apply_request(i_req.action, i_req.value, i_req.index));
        end
        o_pending <= expected_q.size();
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Top of the sorted insert table testbench: clock, reset, request stimulus and
// result back-pressure; the verdict comes from sit_table_checker.
// Depends on sit_pkg, sit_if.sv, sorted_insert_table_top and sit_table_checker.
module tb;
    import sit_pkg::*;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 900;
    localparam int DRAIN_CYCLES = 150;

    localparam logic [ACT_W-1:0]        ACT_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN    = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX    = 32'sh7FFF_FFFF;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   idle_pct  = 16;
    int   stall_pct = 86;
    int   fail_count;
    int   pending;

    logic signed [KEY_W-1:0] sent_keys [$];

    sit_in_if  req_ch ();
    sit_out_if rsp_ch ();

    sorted_insert_table_top #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    sit_table_checker #(.TABLE_DEPTH(TABLE_DEPTH)) table_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 i_clk = ~i_clk;

    initial rsp_ch.ready = 1'b0;

    always @(posedge i_clk) begin
        rsp_ch.ready <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // hold the beat until it is taken; ready is sampled at the falling edge
    task automatic issue(input logic [ACT_W-1:0] act, input logic signed [KEY_W-1:0] key,
                         input logic [IDX_W-1:0] idx);
        logic accepted;
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.value  <= key;
        req_ch.index  <= idx;
        do begin
            @(negedge i_clk);
            accepted = req_ch.ready;
            @(posedge i_clk);
        end while (!accepted);
        if (act == ACT_INSERT && sent_keys.size() < TABLE_DEPTH)
            sent_keys.push_back(key);
    endtask

    initial begin
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_INSERT;
        req_ch.value  = '0;
        req_ch.index  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        issue(ACT_SEARCH, 5, 0);
        issue(ACT_READ, 0, 0);
        issue(ACT_READ, 0, 63);
        issue(ACT_UNUSED, KEY_MIN, 63);
        issue(ACT_INSERT, 0, 0);
        issue(ACT_INSERT, KEY_MAX, 63);
        issue(ACT_SEARCH, 5, 0);
        issue(ACT_INSERT, KEY_MIN, 21);
        issue(ACT_INSERT, 0, 42);
        issue(ACT_INSERT, -1, 0);
        issue(ACT_SEARCH, KEY_MIN, 0);
        issue(ACT_SEARCH, KEY_MAX, 0);
        issue(ACT_SEARCH, 1, 0);
        issue(ACT_READ, 0, 0);
        issue(ACT_READ, 0, 4);
        issue(ACT_READ, 0, 5);
        issue(ACT_INSERT, KEY_MAX - 1, 0);
        issue(ACT_SEARCH, KEY_MIN + 1, 0);
        issue(ACT_INSERT, KEY_MAX, 0);
        issue(ACT_READ, KEY_MAX, 6);
        issue(ACT_UNUSED, -1, 0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            logic [ACT_W-1:0]        act;
            logic signed [KEY_W-1:0] key;
            logic [IDX_W-1:0]        idx;
            int unsigned             roll;
            if (n == RANDOM_ITEMS / 3) begin
                idle_pct  = 86;
                stall_pct = 16;
            end else if (n == 2 * RANDOM_ITEMS / 3) begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            roll = $urandom_range(99);
            act  = roll < 12 ? ACT_INSERT : roll < 50 ? ACT_SEARCH :
                   roll < 97 ? ACT_READ : ACT_UNUSED;
            case ($urandom_range(9))
                0, 1, 2, 3: key = $urandom;
                4, 5:       key = $signed($urandom_range(16)) - 8;
                6: begin
                    case ($urandom_range(3))
                        0:       key = KEY_MIN;
                        1:       key = KEY_MAX;
                        2:       key = -1;
                        default: key = 0;
                    endcase
                end
                default: begin
                    if (sent_keys.size() == 0)
                        key = $urandom;
                    else
                        key = sent_keys[$urandom_range(sent_keys.size() - 1)]
                              + $signed($urandom_range(2)) - 1;
                end
            endcase
            if (sent_keys.size() != 0 && $urandom_range(9) < 8)
                idx = IDX_W'($urandom_range(sent_keys.size() - 1));
            else
                idx = IDX_W'($urandom_range(63));
            issue(act, key, idx);
        end

        req_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sorted_insert_table_top.f -----
+incdir+design
design/sit_pkg.sv
design/sit_if.sv
design/sit_ctrl.sv
design/sit_datapath.sv
design/sorted_insert_table_top.sv
test/sit_table_checker.sv
test/tb.sv
